### sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, codes and character constants for the line tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int MAX_RESULTS = 3;

    // result kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // line status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_LIMIT  = 2'd2;

    // open quote kinds
    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_SINGLE = 2'd1;
    localparam logic [1:0] Q_DOUBLE = 2'd2;

    // configuration register indexes
    localparam logic CFG_MAX_TOKENS  = 1'b0;
    localparam logic CFG_BUFFER_SIZE = 1'b1;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_VT        = 8'h0B;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic [5:0] token_index;
        logic [1:0] status;
        logic       last_out;
    } res_t;

    typedef struct packed {
        res_t [MAX_RESULTS-1:0] res;
        logic [1:0]             count;
    } burst_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
               (c == CH_LF) || (c == CH_FF) || (c == CH_VT);
    endfunction

    function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] ch,
                                    input logic [5:0] idx, input logic [1:0] st,
                                    input logic lst);
        res_t r;
        r.kind        = kind;
        r.char_out    = ch;
        r.token_index = idx;
        r.status      = st;
        r.last_out    = lst;
        return r;
    endfunction

endpackage

### sv/slt_parse.sv
// ----------------------------------------------------------------------------
// slt_parse
// Line state registers and the per-byte tokenizing step; yields up to three
// results for each accepted request.
// ----------------------------------------------------------------------------
module slt_parse #(
    parameter int TCW = 7,
    parameter int LCW = 13
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      byte_req,
    input  logic            has_byte,
    input  logic            last,
    input  logic [TCW-1:0]  tok_lim,
    input  logic [LCW-1:0]  buf_lim,
    output slt_pkg::burst_t burst
);
    import slt_pkg::*;

    logic           in_token_reg, in_token_next;
    logic           esc_reg, esc_next;
    logic [1:0]     quote_reg, quote_next;
    logic [TCW-1:0] tok_cnt_reg, tok_cnt_next;
    logic [LCW-1:0] line_cnt_reg, line_cnt_next;
    logic [1:0]     err_reg, err_next;

    always_comb begin
        logic [1:0]     k;
        logic [LCW-1:0] lc_inc;
        logic [7:0]     closer;
        logic [5:0]     idx_now;
        k             = 2'd0;
        in_token_next = in_token_reg;
        esc_next      = esc_reg;
        quote_next    = quote_reg;
        tok_cnt_next  = tok_cnt_reg;
        line_cnt_next = line_cnt_reg;
        err_next      = err_reg;
        burst         = '0;
        idx_now       = 6'(32'(tok_cnt_reg));
        closer        = (quote_reg == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        lc_inc        = (line_cnt_reg < buf_lim) ? line_cnt_reg + LCW'(1) : line_cnt_reg;

        if (has_byte && (err_reg == ST_OK)) begin
            line_cnt_next = lc_inc;
            if (lc_inc >= buf_lim) begin
                err_next = ST_LIMIT;
            end else if (esc_reg) begin
                in_token_next = 1'b1;
                esc_next      = 1'b0;
                burst.res[k]  = mk_res(KIND_CHAR, byte_req, idx_now, ST_OK, 1'b0);
                k             = k + 2'd1;
            end else if (byte_req == CH_BACKSLASH) begin
                in_token_next = 1'b1;
                esc_next      = 1'b1;
            end else if (quote_reg != Q_NONE) begin
                if (byte_req == closer) begin
                    quote_next = Q_NONE;
                end else begin
                    burst.res[k] = mk_res(KIND_CHAR, byte_req, idx_now, ST_OK, 1'b0);
                    k            = k + 2'd1;
                end
            end else if ((byte_req == CH_SQUOTE) || (byte_req == CH_DQUOTE)) begin
                in_token_next = 1'b1;
                quote_next    = (byte_req == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
            end else if (is_blank(byte_req)) begin
                if (in_token_reg) begin
                    in_token_next = 1'b0;
                    if (tok_cnt_reg >= tok_lim) begin
                        err_next = ST_LIMIT;
                    end else begin
                        burst.res[k] = mk_res(KIND_END, 8'd0, idx_now, ST_OK, 1'b0);
                        k            = k + 2'd1;
                        tok_cnt_next = tok_cnt_reg + TCW'(1);
                    end
                end
            end else begin
                in_token_next = 1'b1;
                burst.res[k]  = mk_res(KIND_CHAR, byte_req, idx_now, ST_OK, 1'b0);
                k             = k + 2'd1;
            end
        end

        if (last) begin
            if (err_next == ST_OK) begin
                if (esc_next || (quote_next != Q_NONE)) begin
                    err_next = ST_SYNTAX;
                end else if (in_token_next) begin
                    // close the open token at line end
                    if (tok_cnt_next >= tok_lim) begin
                        err_next = ST_LIMIT;
                    end else begin
                        burst.res[k] = mk_res(KIND_END, 8'd0, 6'(32'(tok_cnt_next)),
                                              ST_OK, 1'b0);
                        k            = k + 2'd1;
                    end
                end
            end
            burst.res[k]  = mk_res(KIND_STATUS, 8'd0, 6'd0, err_next, 1'b1);
            k             = k + 2'd1;
            // back to a clean line
            in_token_next = 1'b0;
            esc_next      = 1'b0;
            quote_next    = Q_NONE;
            tok_cnt_next  = '0;
            line_cnt_next = '0;
            err_next      = ST_OK;
        end
        burst.count = k;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_token_reg <= 1'b0;
            esc_reg      <= 1'b0;
            quote_reg    <= Q_NONE;
            tok_cnt_reg  <= '0;
            line_cnt_reg <= '0;
            err_reg      <= ST_OK;
        end else if (accept) begin
            in_token_reg <= in_token_next;
            esc_reg      <= esc_next;
            quote_reg    <= quote_next;
            tok_cnt_reg  <= tok_cnt_next;
            line_cnt_reg <= line_cnt_next;
            err_reg      <= err_next;
        end
    end

endmodule

### sv/slt_outq.sv
// ----------------------------------------------------------------------------
// slt_outq
// Four-entry result queue: takes up to three results per request and drains
// one per cycle to the output stream while m_tready is high.
// ----------------------------------------------------------------------------
module slt_outq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  slt_pkg::burst_t burst,
    output logic            room,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,   // char_out[7:0], token_index[13:8], status[15:14]
    output logic [1:0]      m_tuser,   // kind[1:0]
    output logic            m_tlast
);
    import slt_pkg::*;

    localparam int DEPTH = 4;

    res_t       mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [2:0] push_cnt;
    res_t       head;

    assign head     = mem_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = {head.status, head.token_index, head.char_out};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last_out;
    // worst case request needs three free slots
    assign room     = (cnt_reg <= 3'd1);
    assign pop      = m_tvalid && m_tready;
    assign push_cnt = load ? {1'b0, burst.count} : 3'd0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt[1:0];
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        cnt_next    = cnt_reg + push_cnt - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                if (2'(i) < burst.count) begin
                    mem_reg[wr_ptr_reg + 2'(i)] <= burst.res[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(DEPTH))
        else $error("result queue overfilled");

    a_no_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > 3'd1) |-> !room)
        else $error("queue offers room without three free slots");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_STATUS)) |-> m_tlast)
        else $error("status result not marked last");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == cnt_reg[1:0])
        else $error("queue pointers disagree with fill count");

endmodule

### sv/shell_line_tokenizer.sv
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// Splits a command line, one byte per request, into shell-style tokens with
// quotes and backslash escapes, and reports a status at the end of each line.
//
//   channel   dir  tdata                  tuser      tlast
//   s_        in   byte_req[7:0]          has_byte   last
//   m_        out  char_out, token_index, kind[1:0]  last_out
//                  status
//   cfg_      in   index 0 max_tokens, 1 buffer_size (cfg_data)
//
// A byte is taken when s_tvalid and s_tready are both high; its results, if any,
// are registered into the result queue behind those still queued. A request gives
// up to three results; the single output port drains one per cycle while m_tready is high.
// Input is taken while at most one result is queued.
// Reset clears line state and loads limits 16 tokens and 256 bytes.
// A stall on m_tready holds the result and stops input once two are queued.
// ----------------------------------------------------------------------------
module shell_line_tokenizer #(
    parameter int MAX_TOKEN_LIMIT  = 64,
    parameter int MAX_BUFFER_LIMIT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // byte_req[7:0]
    input  logic        s_tuser,    // has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // char_out[7:0], token_index[13:8], status[15:14]
    output logic [1:0]  m_tuser,    // kind[1:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    import slt_pkg::*;

    localparam int TCW     = $clog2(MAX_TOKEN_LIMIT + 1);
    localparam int LCW     = $clog2(MAX_BUFFER_LIMIT + 1);
    localparam int TOK_RST = (16 > MAX_TOKEN_LIMIT) ? MAX_TOKEN_LIMIT : 16;
    localparam int BUF_RST = (256 > MAX_BUFFER_LIMIT) ? MAX_BUFFER_LIMIT : 256;

    logic [TCW-1:0] tok_lim_reg, tok_lim_next;
    logic [LCW-1:0] buf_lim_reg, buf_lim_next;
    logic           accept;
    logic           room;
    burst_t         burst;

    assign cfg_ready = 1'b1;
    assign s_tready  = room;
    assign accept    = s_tvalid && s_tready;

    // clamp limits at write time
    always_comb begin
        tok_lim_next = tok_lim_reg;
        buf_lim_next = buf_lim_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_TOKENS: begin
                    if (32'(cfg_data[6:0]) > 32'(MAX_TOKEN_LIMIT)) begin
                        tok_lim_next = TCW'(MAX_TOKEN_LIMIT);
                    end else begin
                        tok_lim_next = TCW'(32'(cfg_data[6:0]));
                    end
                end
                CFG_BUFFER_SIZE: begin
                    if (32'(cfg_data) > 32'(MAX_BUFFER_LIMIT)) begin
                        buf_lim_next = LCW'(MAX_BUFFER_LIMIT);
                    end else begin
                        buf_lim_next = LCW'(32'(cfg_data));
                    end
                end
                default: begin
                    tok_lim_next = tok_lim_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_lim_reg <= TCW'(TOK_RST);
            buf_lim_reg <= LCW'(BUF_RST);
        end else begin
            tok_lim_reg <= tok_lim_next;
            buf_lim_reg <= buf_lim_next;
        end
    end

    slt_parse #(
        .TCW(TCW),
        .LCW(LCW)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .byte_req (s_tdata),
        .has_byte (s_tuser),
        .last     (s_tlast),
        .tok_lim  (tok_lim_reg),
        .buf_lim  (buf_lim_reg),
        .burst    (burst)
    );

    slt_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .burst    (burst),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for shell_line_tokenizer. Lines go in one byte per
// request; a line tokenizer model kept in the bench predicts every token
// character, token end and line status, and each result on m_ is compared
// field by field in arrival order. Covers quoting, escapes, separators,
// syntax errors and both limits, then random lines under several limit
// settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;

    import slt_pkg::*;

    typedef logic [7:0] line_t[$];

    localparam int TOKEN_CAP     = 64;
    localparam int LINE_CAP      = 4096;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_GUARD   = 5000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [12:0] cfg_data  = '0;

    // tokenizer model: limits and per-line state
    logic [6:0]  lim_tokens = 7'd16;
    logic [12:0] lim_bytes  = 13'd256;
    bit          tk_in_token = 1'b0;
    bit          tk_escape   = 1'b0;
    logic [1:0]  tk_quote    = Q_NONE;
    int unsigned tk_count    = 0;
    int unsigned tk_len      = 0;
    logic [1:0]  tk_error    = ST_OK;

    res_t token_stream_q[$];

    int fail_count  = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int rx_left     = 0;
    bit gaps_on     = 1'b0;
    bit rx_stall_en = 1'b0;

    shell_line_tokenizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Tokenizer model
    // ------------------------------------------------------------------------
    function automatic bit is_white(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
               c == CH_FF || c == CH_VT;
    endfunction

    function automatic int unsigned token_cap();
        return (lim_tokens > TOKEN_CAP) ? TOKEN_CAP : lim_tokens;
    endfunction

    function automatic int unsigned line_cap();
        return (lim_bytes > LINE_CAP) ? LINE_CAP : lim_bytes;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [7:0] ch,
                                        logic [5:0] idx, logic [1:0] st, logic lst);
        res_t r;
        r.kind        = kind;
        r.char_out    = ch;
        r.token_index = idx;
        r.status      = st;
        r.last_out    = lst;
        token_stream_q.push_back(r);
    endfunction

    function automatic void restart_line();
        tk_in_token = 1'b0;
        tk_escape   = 1'b0;
        tk_quote    = Q_NONE;
        tk_count    = 0;
        tk_len      = 0;
        tk_error    = ST_OK;
    endfunction

    function automatic void end_token();
        tk_in_token = 1'b0;
        if (tk_count >= token_cap()) begin
            tk_error = ST_LIMIT;
        end else begin
            push_result(KIND_END, 8'h00, tk_count[5:0], ST_OK, 1'b0);
            tk_count++;
        end
    endfunction

    function automatic void take_byte(logic [7:0] c);
        if (tk_len < line_cap())
            tk_len++;
        if (tk_len >= line_cap()) begin
            tk_error = ST_LIMIT;
            return;
        end
        if (tk_escape) begin
            tk_in_token = 1'b1;
            tk_escape   = 1'b0;
            push_result(KIND_CHAR, c, tk_count[5:0], ST_OK, 1'b0);
            return;
        end
        if (c == CH_BACKSLASH) begin
            tk_in_token = 1'b1;
            tk_escape   = 1'b1;
            return;
        end
        if (tk_quote != Q_NONE) begin
            // only the quote kind that opened the group closes it
            if ((tk_quote == Q_SINGLE && c == CH_SQUOTE) ||
                (tk_quote == Q_DOUBLE && c == CH_DQUOTE))
                tk_quote = Q_NONE;
            else
                push_result(KIND_CHAR, c, tk_count[5:0], ST_OK, 1'b0);
            return;
        end
        if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            tk_in_token = 1'b1;
            tk_quote    = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
            return;
        end
        if (is_white(c)) begin
            if (tk_in_token)
                end_token();
            return;
        end
        tk_in_token = 1'b1;
        push_result(KIND_CHAR, c, tk_count[5:0], ST_OK, 1'b0);
    endfunction

    function automatic void tokenize_request(logic [7:0] c, bit has, bit lst);
        if (has && tk_error == ST_OK)
            take_byte(c);
        if (!lst)
            return;
        if (tk_error == ST_OK) begin
            if (tk_escape || tk_quote != Q_NONE)
                tk_error = ST_SYNTAX;
            else if (tk_in_token)
                end_token();
        end
        push_result(KIND_STATUS, 8'h00, 6'd0, tk_error, 1'b1);
        restart_line();
    endfunction

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (token_stream_q.size() == 0) begin
                $error("unexpected result: kind %0d", m_tuser);
                fail_count++;
            end else begin
                want = token_stream_q.pop_front();
                if (m_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    fail_count++;
                end
                if (m_tdata[7:0] !== want.char_out) begin
                    $error("char_out: expected %0h, got %0h", want.char_out, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[13:8] !== want.token_index) begin
                    $error("token_index: expected %0d, got %0d",
                           want.token_index, m_tdata[13:8]);
                    fail_count++;
                end
                if (m_tdata[15:14] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[15:14]);
                    fail_count++;
                end
                if (m_tlast !== want.last_out) begin
                    $error("last_out: expected %0d, got %0d", want.last_out, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // receiver: alternate ready windows and stalls of random length
    always @(posedge aclk) begin
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (!rx_stall_en || !m_tready) begin
            m_tready <= 1'b1;
            rx_left  <= $urandom_range(1, 10);
        end else begin
            m_tready <= 1'b0;
            rx_left  <= $urandom_range(1, 5);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(logic [7:0] b, bit has, bit lst);
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        tokenize_request(b, has, lst);
        if (has || lst)
            items_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // hold input until every predicted result has been seen
    task automatic wait_all_results();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (token_stream_q.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_limits(logic [6:0] tokens, logic [12:0] bytes);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_TOKENS;
        cfg_data  <= {6'd0, tokens};
        do @(posedge aclk); while (!cfg_ready);
        lim_tokens = tokens;
        cfg_index <= CFG_BUFFER_SIZE;
        cfg_data  <= bytes;
        do @(posedge aclk); while (!cfg_ready);
        lim_bytes = bytes;
        cfg_valid <= 1'b0;
    endtask

    // send one line; close it with a byteless request when asked or when empty
    task automatic send_line(line_t bytes, bit marker, int noise_pct);
        for (int i = 0; i < bytes.size(); i++) begin
            if (noise_pct > 0 && $urandom_range(1, 100) <= noise_pct)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(bytes[i], 1'b1, !marker && i == bytes.size() - 1);
        end
        if (marker || bytes.size() == 0)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    function automatic line_t to_bytes(string s);
        line_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] pick_white();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            3: return CH_LF;
            4: return CH_FF;
            default: return CH_VT;
        endcase
    endfunction

    function automatic line_t random_line();
        line_t       q;
        int          shape;
        int          ntok;
        logic [7:0]  c;
        logic [7:0]  qc;
        shape = $urandom_range(0, 9);
        if (shape == 9)
            return q;
        if (shape == 7) begin
            repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        if ($urandom_range(0, 3) == 0)
            q.push_back(pick_white());
        ntok = $urandom_range(1, 5);
        for (int t = 0; t < ntok; t++) begin
            if (t > 0)
                repeat ($urandom_range(1, 2)) q.push_back(pick_white());
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0: begin
                        repeat ($urandom_range(1, 4)) begin
                            c = 8'($urandom_range(8'h21, 8'hFF));
                            if (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BACKSLASH)
                                c = "w";
                            q.push_back(c);
                        end
                    end
                    1, 2: begin
                        qc = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                        q.push_back(qc);
                        repeat ($urandom_range(0, 4)) begin
                            c = 8'($urandom_range(8'h20, 8'hFF));
                            if (c == qc)
                                c = "k";
                            // escaped byte may be anything, the closing quote too
                            if (c == CH_BACKSLASH) begin
                                q.push_back(c);
                                c = 8'($urandom_range(0, 255));
                            end
                            q.push_back(c);
                        end
                        q.push_back(qc);
                    end
                    default: begin
                        q.push_back(CH_BACKSLASH);
                        q.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end
        end
        if ($urandom_range(0, 3) == 0)
            q.push_back(pick_white());
        // broken line: leave a quote or an escape open
        if (shape == 8) begin
            case ($urandom_range(0, 2))
                0: q.push_back(CH_SQUOTE);
                1: q.push_back(CH_DQUOTE);
                default: q.push_back(CH_BACKSLASH);
            endcase
        end
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_lines();
        line_t q;
        gaps_on     = 1'b0;
        rx_stall_en = 1'b0;
        // escaped blank, tab, double quotes holding a single quote, empty quotes
        send_line(to_bytes("a\\ b\t\"x 'y\"\n''"), 1'b0, 0);
        // byteless request inside a line does nothing
        push_item(8'h5A, 1'b0, 1'b0);
        q = {CH_SPACE, CH_CR, CH_FF, CH_VT, 8'h00, 8'hFF};
        send_line(q, 1'b0, 0);
        // empty line
        push_item(8'hC3, 1'b0, 1'b1);
        // open quote, then dangling escape
        send_line(to_bytes("'a"), 1'b0, 0);
        send_line(to_bytes("b\\"), 1'b0, 0);
    endtask

    task automatic test_limit_registers();
        line_t none;
        gaps_on     = 1'b1;
        rx_stall_en = 1'b1;
        set_limits(7'd1, 13'd8191);
        send_line(to_bytes("a b"), 1'b0, 0);
        set_limits(7'd0, 13'd8191);
        send_line(to_bytes("z"), 1'b0, 0);
        set_limits(7'd127, 13'd1);
        send_line(to_bytes("q"), 1'b0, 0);
        send_line(none, 1'b1, 0);
        set_limits(7'd127, 13'd0);
        send_line(to_bytes("q"), 1'b1, 0);
        send_line(none, 1'b1, 0);
        set_limits(7'd64, 13'd2);
        send_line(to_bytes("ab"), 1'b0, 0);
        // third token passes the cap: its character still goes out, then the line fails
        set_limits(7'd2, 13'd4096);
        send_line(to_bytes("a b c d"), 1'b0, 0);
    endtask

    task automatic test_random_lines();
        int first;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_limits(7'd16, 13'd256);
                1: set_limits(7'($urandom_range(2, 4)), 13'($urandom_range(10, 24)));
                2: set_limits(7'd64, 13'd4096);
                default: set_limits(7'($urandom_range(1, 127)), 13'($urandom_range(1, 60)));
            endcase
            gaps_on     = (phase != 0);
            rx_stall_en = (phase != 2);
            first = items_sent;
            while (items_sent - first < 14)
                send_line(random_line(), $urandom_range(0, 3) == 0, 8);
        end
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_lines();
        test_limit_registers();
        test_random_lines();
        wait_all_results();
        repeat (10) @(posedge aclk);
        if (token_stream_q.size() != 0) begin
            $error("%0d predicted results never arrived", token_stream_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
